// ===== sv/acioc_pkg.sv =====
// ----------------------------------------------------------------------------
// acioc_pkg: shared constants for the accumulatorless IO control unit
// Field widths, default store depths, item kinds and instruction opcodes.
// ----------------------------------------------------------------------------
package acioc_pkg;

  // Field widths
  localparam int unsigned AddrW   = 11;
  localparam int unsigned IrW     = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 5;
  localparam int unsigned IoSelW  = 5;

  // Default store depths
  localparam int unsigned MainDepthDef = 2048;
  localparam int unsigned IoDepthDef   = 32;

  // Item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;

  // Opcodes; every other code halts
  localparam logic [OpW-1:0] OpWm  = 5'd1;  // MBR low byte to memory
  localparam logic [OpW-1:0] OpRm  = 5'd2;  // memory to MBR
  localparam logic [OpW-1:0] OpBr  = 5'd3;  // branch to operand
  localparam logic [OpW-1:0] OpWio = 5'd4;  // IOBR low byte to IO buffer
  localparam logic [OpW-1:0] OpRio = 5'd5;  // IO buffer to IOBR
  localparam logic [OpW-1:0] OpWb  = 5'd6;  // operand to MBR
  localparam logic [OpW-1:0] OpWib = 5'd7;  // operand to IOBR

endpackage

// ===== sv/acioc_ram.sv =====
// ----------------------------------------------------------------------------
// acioc_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module acioc_ram #(
  parameter int unsigned Width = acioc_pkg::ByteW,
  parameter int unsigned Depth = acioc_pkg::MainDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/accumulatorless_io_control_unit.sv =====
// ----------------------------------------------------------------------------
// accumulatorless_io_control_unit: one-instruction-per-item control unit
// Main memory and IO buffer in single-port RAMs, fetch/execute sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries load and step items. A load
//   item writes load_byte_i to main memory; a step item fetches the
//   big-endian instruction at PC and executes it.
//   Output channel (out_valid_o/out_ready_i) returns one result per item:
//   the architectural registers after that item.
//   Timing: a load item, or a step while halted, finishes while idle.
//   A step passes through high byte read, low byte read and execute, plus
//   read-back for memory and IO reads; the single main port sets this order.
//   The output register holds one finished result, so the next item is
//   accepted while that result waits; a second finished result waits in the
//   architectural registers and holds off input until the first is taken.
//   Reset: PC, IR, MBR, IOBR, bus and halt clear; then a clearing pass over
//   max(MainDepth, IoDepth) addresses zeroes both RAMs with in_ready_o low.
//   cfg_we_i sets PC to cfg_wdata_i (start address); idle only, user-checked.
// ----------------------------------------------------------------------------
module accumulatorless_io_control_unit #(
  parameter int unsigned MainDepth = acioc_pkg::MainDepthDef,
  parameter int unsigned IoDepth   = acioc_pkg::IoDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [acioc_pkg::AddrW-1:0]   cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [acioc_pkg::AddrW-1:0]   load_address_i,
  input  logic [acioc_pkg::ByteW-1:0]   load_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acioc_pkg::AddrW-1:0]   program_counter_o,
  output logic [acioc_pkg::IrW-1:0]     instruction_word_o,
  output logic [acioc_pkg::OpW-1:0]     opcode_o,
  output logic [acioc_pkg::AddrW-1:0]   operand_value_o,
  output logic [acioc_pkg::AddrW-1:0]   memory_buffer_o,
  output logic [acioc_pkg::AddrW-1:0]   io_buffer_register_o,
  output logic [acioc_pkg::ByteW-1:0]   bus_value_o,
  output logic                          halted_o
);

  localparam int unsigned AW       = acioc_pkg::AddrW;
  localparam int unsigned BW       = acioc_pkg::ByteW;
  localparam int unsigned MainAw   = $clog2(MainDepth);
  localparam int unsigned IoAw     = $clog2(IoDepth);
  localparam int unsigned ClrDepth = (MainDepth > IoDepth) ? MainDepth : IoDepth;
  localparam int unsigned ClrAw    = $clog2(ClrDepth);

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFetch = 2'd1;  // low byte read, high byte back
  localparam logic [1:0] StExec  = 2'd2;  // low byte back, decode, data access
  localparam logic [1:0] StRead  = 2'd3;  // read data back

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       pc_q, pc_d;
  logic [15:0]         ir_q, ir_d;
  logic [AW-1:0]       mbr_q, mbr_d;
  logic [AW-1:0]       iobr_q, iobr_d;
  logic [BW-1:0]       bus_q, bus_d;
  logic                halt_q, halt_d;
  logic [BW-1:0]       ir_hi_q, ir_hi_d;
  logic                rd_io_q, rd_io_d;
  logic                main_ok_q, main_ok_d;
  logic                io_ok_q, io_ok_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [ClrAw-1:0]    clr_cnt_q, clr_cnt_d;
  logic                clr_done_q, clr_done_d;

  // Output payload
  logic [AW-1:0]       out_pc_q;
  logic [15:0]         out_ir_q;
  logic [AW-1:0]       out_mbr_q;
  logic [AW-1:0]       out_iobr_q;
  logic [BW-1:0]       out_bus_q;
  logic                out_halt_q;

  // RAM ports
  logic                main_we;
  logic [MainAw-1:0]   main_addr;
  logic [BW-1:0]       main_wdata;
  logic [BW-1:0]       main_rdata;
  logic                io_we;
  logic [IoAw-1:0]     io_addr;
  logic [BW-1:0]       io_wdata;
  logic [BW-1:0]       io_rdata;

  // Requests before range check and clearing override
  logic [AW-1:0]       main_req_addr;
  logic                main_req_wr;
  logic [BW-1:0]       main_req_wdata;
  logic [AW-1:0]       io_req_addr;
  logic                io_req_wr;
  logic                main_inr;
  logic                io_inr;
  logic                clr_main;
  logic                clr_io;

  logic                in_acc;
  logic                done;
  logic                slot_free;
  logic                load_out;
  logic [BW-1:0]       main_rd_byte;
  logic [BW-1:0]       io_rd_byte;
  logic [15:0]         ir_word;
  logic [acioc_pkg::OpW-1:0] op;
  logic [AW-1:0]       arg;

  assign in_ready_o   = (state_q == StIdle) && clr_done_q && !pend_q;
  assign in_acc       = in_valid_i && in_ready_o;
  assign main_rd_byte = main_ok_q ? main_rdata : '0;
  assign io_rd_byte   = io_ok_q ? io_rdata : '0;
  assign ir_word      = {ir_hi_q, main_rd_byte};
  assign op           = ir_word[15:11];
  assign arg          = ir_word[AW-1:0];

  // Fetch / execute sequencer
  always_comb begin
    state_d        = state_q;
    pc_d           = pc_q;
    ir_d           = ir_q;
    mbr_d          = mbr_q;
    iobr_d         = iobr_q;
    bus_d          = bus_q;
    halt_d         = halt_q;
    ir_hi_d        = ir_hi_q;
    rd_io_d        = rd_io_q;
    main_req_addr  = pc_q;
    main_req_wr    = 1'b0;
    main_req_wdata = load_byte_i;
    io_req_addr    = '0;
    io_req_wr      = 1'b0;
    done           = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (kind_i == acioc_pkg::KindStep && !halt_q) begin
            state_d = StFetch;  // high byte read at PC
          end else begin
            done = 1'b1;
            if (kind_i == acioc_pkg::KindLoad) begin
              main_req_addr = load_address_i;
              main_req_wr   = 1'b1;
            end
          end
        end
      end
      StFetch: begin
        main_req_addr = pc_q + AW'(1);
        ir_hi_d       = main_rd_byte;
        state_d       = StExec;
      end
      StExec: begin
        ir_d    = ir_word;
        pc_d    = pc_q + AW'(2);
        bus_d   = ir_word[BW-1:0];
        state_d = StIdle;
        done    = 1'b1;
        case (op)
          acioc_pkg::OpWm: begin
            bus_d          = mbr_q[BW-1:0];
            main_req_addr  = arg;
            main_req_wr    = 1'b1;
            main_req_wdata = mbr_q[BW-1:0];
          end
          acioc_pkg::OpRm: begin
            main_req_addr = arg;
            rd_io_d       = 1'b0;
            state_d       = StRead;
            done          = 1'b0;
          end
          acioc_pkg::OpBr: begin
            pc_d = arg;
          end
          acioc_pkg::OpWio: begin
            bus_d       = iobr_q[BW-1:0];
            io_req_addr = {{(AW-acioc_pkg::IoSelW){1'b0}}, arg[acioc_pkg::IoSelW-1:0]};
            io_req_wr   = 1'b1;
          end
          acioc_pkg::OpRio: begin
            io_req_addr = {{(AW-acioc_pkg::IoSelW){1'b0}}, arg[acioc_pkg::IoSelW-1:0]};
            rd_io_d     = 1'b1;
            state_d     = StRead;
            done        = 1'b0;
          end
          acioc_pkg::OpWb: begin
            mbr_d = arg;
          end
          acioc_pkg::OpWib: begin
            iobr_d = arg;
          end
          default: begin
            halt_d = 1'b1;
          end
        endcase
      end
      StRead: begin
        done    = 1'b1;
        state_d = StIdle;
        if (rd_io_q) begin
          bus_d  = io_rd_byte;
          iobr_d = {{(AW-BW){1'b0}}, io_rd_byte};
        end else begin
          bus_d = main_rd_byte;
          mbr_d = {{(AW-BW){1'b0}}, main_rd_byte};
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // start address write reloads PC
    if (cfg_we_i) begin
      pc_d = cfg_wdata_i;
    end
  end

  // Range checks; addresses past a store's depth write nothing and read zero
  assign main_inr  = {1'b0, main_req_addr} < (AW+1)'(MainDepth);
  assign io_inr    = {1'b0, io_req_addr} < (AW+1)'(IoDepth);
  assign main_ok_d = main_inr;
  assign io_ok_d   = io_inr;

  // Clearing pass after reset
  assign clr_main = {{(32-ClrAw){1'b0}}, clr_cnt_q} < 32'(MainDepth);
  assign clr_io   = {{(32-ClrAw){1'b0}}, clr_cnt_q} < 32'(IoDepth);
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_done_d = clr_done_q;
    if (!clr_done_q) begin
      clr_cnt_d = clr_cnt_q + ClrAw'(1);
      if (clr_cnt_q == ClrAw'(ClrDepth - 1)) begin
        clr_done_d = 1'b1;
      end
    end
  end

  // RAM port muxing
  always_comb begin
    if (!clr_done_q) begin
      main_we    = clr_main;
      main_addr  = clr_cnt_q[MainAw-1:0];
      main_wdata = '0;
      io_we      = clr_io;
      io_addr    = clr_cnt_q[IoAw-1:0];
      io_wdata   = '0;
    end else begin
      main_we    = main_req_wr && main_inr;
      main_addr  = main_req_addr[MainAw-1:0];
      main_wdata = main_req_wdata;
      io_we      = io_req_wr && io_inr;
      io_addr    = io_req_addr[IoAw-1:0];
      io_wdata   = iobr_q[BW-1:0];
    end
  end

  // Output stage: a result waits in the architectural registers if busy
  assign slot_free   = !out_valid_q || out_ready_i;
  assign load_out    = (done || pend_q) && slot_free;
  assign pend_d      = (done || pend_q) && !slot_free;
  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      ir_q        <= '0;
      mbr_q       <= '0;
      iobr_q      <= '0;
      bus_q       <= '0;
      halt_q      <= 1'b0;
      rd_io_q     <= 1'b0;
      main_ok_q   <= 1'b0;
      io_ok_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ir_q        <= ir_d;
      mbr_q       <= mbr_d;
      iobr_q      <= iobr_d;
      bus_q       <= bus_d;
      halt_q      <= halt_d;
      rd_io_q     <= rd_io_d;
      main_ok_q   <= main_ok_d;
      io_ok_q     <= io_ok_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_done_q  <= clr_done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ir_hi_q <= ir_hi_d;
    if (load_out) begin
      out_pc_q   <= pc_d;
      out_ir_q   <= ir_d;
      out_mbr_q  <= mbr_d;
      out_iobr_q <= iobr_d;
      out_bus_q  <= bus_d;
      out_halt_q <= halt_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign program_counter_o    = out_pc_q;
  assign instruction_word_o   = out_ir_q;
  assign opcode_o             = out_ir_q[15:11];
  assign operand_value_o      = out_ir_q[AW-1:0];
  assign memory_buffer_o      = out_mbr_q;
  assign io_buffer_register_o = out_iobr_q;
  assign bus_value_o          = out_bus_q;
  assign halted_o             = out_halt_q;

  // Main memory
  acioc_ram #(
    .Width (BW),
    .Depth (MainDepth),
    .AddrW (MainAw)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .addr_i  (main_addr),
    .wdata_i (main_wdata),
    .rdata_o (main_rdata)
  );

  // IO buffer
  acioc_ram #(
    .Width (BW),
    .Depth (IoDepth),
    .AddrW (IoAw)
  ) u_io_ram (
    .clk_i   (clk_i),
    .we_i    (io_we),
    .addr_i  (io_addr),
    .wdata_i (io_wdata),
    .rdata_o (io_rdata)
  );

endmodule
